// ===== rtl/core/quantized_silu_channel_scale_assert.svh =====
// ----------------------------------------------------------------------------
// quantized_silu_channel_scale assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef QUANTIZED_SILU_CHANNEL_SCALE_ASSERT_SVH
`define QUANTIZED_SILU_CHANNEL_SCALE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define QSCS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qsilu assertion failed");

// next-cycle implication, disabled in reset
`define QSCS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qsilu assertion failed");

`endif

// ===== rtl/core/qsilu_pkg.sv =====
// ----------------------------------------------------------------------------
// qsilu_pkg
// Shared constants, types and helpers of the quantized SiLU datapath.
// ----------------------------------------------------------------------------
package qsilu_pkg;

  localparam int CHANNELS = 1024;
  localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FACTOR_W = 24;

  // register indexes on the configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_SCALE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_ZP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_OUT_SCALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_ZP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_USE_SMOOTH     = 3'd4;

  localparam logic [31:0] RST_INPUT_SCALE   = 32'h0100_0000;
  localparam logic [31:0] RST_INV_OUT_SCALE = 32'h0001_0000;

  // pipeline depths of the sub-units
  localparam int EXP_LAT = 12;
  localparam int DIV_LAT = 35;

  // exp constants, fixed point
  localparam logic signed [63:0] ONE_Q30       = 64'sd1073741824;
  localparam logic signed [32:0] EXP_CLAMP_Q24 = 33'sd1476395008;
  localparam logic signed [63:0] LOG2E_Q30     = 64'sd1549082005;
  localparam logic signed [51:0] LN2_HI_MANT   = 52'sd355;
  localparam logic signed [51:0] LN2_LO_Q40    = 52'sd233310254;
  localparam logic signed [31:0] PC6 = 32'sd213414;
  localparam logic signed [31:0] PC5 = 32'sd1501306;
  localparam logic signed [31:0] PC4 = 32'sd8947976;
  localparam logic signed [31:0] PC3 = 32'sd44738308;
  localparam logic signed [31:0] PC2 = 32'sd178956958;
  localparam logic signed [31:0] PC1 = 32'sd536870925;

  typedef struct packed {
    logic [31:0] inverse_output_scale;
    logic [7:0]  output_zero_point;
    logic        use_smooth;
  } req_cfg_t;

  // divide by 2^30, truncating toward zero
  function automatic logic signed [63:0] trunc_q30(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = x + (x[63] ? 64'sd1073741823 : 64'sd0);
    return y >>> 30;
  endfunction

  function automatic logic signed [31:0] horner_coef(input int k);
    logic signed [31:0] c;
    case (k)
      6:       c = PC4;
      7:       c = PC3;
      8:       c = PC2;
      default: c = PC1;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/qsilu_ram.sv =====
// ----------------------------------------------------------------------------
// qsilu_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
module qsilu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/core/qsilu_exp.sv =====
// ----------------------------------------------------------------------------
// qsilu_exp
// Pipelined exp(-v): clamp, range reduction and degree-7 polynomial.
// ----------------------------------------------------------------------------
module qsilu_exp
  import qsilu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] in_v,
  output logic               out_valid,
  output logic signed [31:0] out_v,
  output logic signed [7:0]  out_n,
  output logic [31:0]        out_e
);

  logic [EXP_LAT-1:0] vld;
  logic signed [31:0] v_q [EXP_LAT];
  logic signed [31:0] x_q [3];
  logic signed [63:0] prod1;
  logic signed [7:0]  n_q [2:EXP_LAT-1];
  logic signed [51:0] a3;
  logic signed [51:0] b3;
  logic signed [31:0] r_q [4:EXP_LAT-2];
  logic signed [31:0] p_q [5:9];
  logic signed [31:0] q10;
  logic [31:0]        e11;

  logic signed [32:0] xneg;
  logic signed [31:0] x_c;
  logic [63:0]        pm;
  logic [9:0]         nmag;
  logic [9:0]         nsig;
  logic               round_up;
  logic signed [51:0] a_c;
  logic signed [51:0] b_c;
  logic signed [51:0] s_adj;
  logic signed [63:0] e_s;

  always_comb begin
    xneg = -{in_v[31], in_v};
    if (xneg > EXP_CLAMP_Q24) begin
      x_c = EXP_CLAMP_Q24[31:0];
    end else if (xneg < -EXP_CLAMP_Q24) begin
      x_c = 32'(-EXP_CLAMP_Q24);
    end else begin
      x_c = xneg[31:0];
    end
  end

  // n = x * log2e, rounded half to even
  always_comb begin
    pm       = prod1[63] ? (64'd0 - prod1) : prod1;
    round_up = (pm[53:0] > {1'b1, 53'd0}) || ((pm[53:0] == {1'b1, 53'd0}) && pm[54]);
    nmag     = pm[63:54] + {9'd0, round_up};
    nsig     = prod1[63] ? (10'd0 - nmag) : nmag;
  end

  assign a_c = (52'(x_q[2]) <<< 16) - ((52'(n_q[2]) * LN2_HI_MANT) <<< 31);
  assign b_c = 52'(n_q[2]) * LN2_LO_Q40;
  assign s_adj = a3 + b3 + ((a3 + b3) < 0 ? 52'sd1023 : 52'sd0);

  assign e_s = trunc_q30(64'(q10) * 64'(r_q[10])) + 64'(r_q[10]) + ONE_Q30;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[EXP_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_q[0] <= in_v;
      for (int k = 1; k < EXP_LAT; k++) begin
        v_q[k] <= v_q[k-1];
      end
      x_q[0] <= x_c;
      x_q[1] <= x_q[0];
      x_q[2] <= x_q[1];
      prod1  <= 64'(x_q[0]) * LOG2E_Q30;
      n_q[2] <= nsig[7:0];
      for (int k = 3; k < EXP_LAT; k++) begin
        n_q[k] <= n_q[k-1];
      end
      a3 <= a_c;
      b3 <= b_c;
      r_q[4] <= 32'(s_adj >>> 10);
      for (int k = 5; k <= EXP_LAT - 2; k++) begin
        r_q[k] <= r_q[k-1];
      end
      // horner steps, one product each
      p_q[5] <= 32'(trunc_q30(64'(PC6) * 64'(r_q[4]))) + PC5;
      for (int k = 6; k <= 9; k++) begin
        p_q[k] <= 32'(trunc_q30(64'(p_q[k-1]) * 64'(r_q[k-1]))) + horner_coef(k);
      end
      q10 <= 32'(trunc_q30(64'(p_q[9]) * 64'(r_q[9])));
      e11 <= e_s[63] ? 32'd0 : e_s[31:0];
    end
  end

  assign out_valid = vld[EXP_LAT-1];
  assign out_v     = v_q[EXP_LAT-1];
  assign out_n     = n_q[EXP_LAT-1];
  assign out_e     = e11;

endmodule

// ===== rtl/core/qsilu_div.sv =====
// ----------------------------------------------------------------------------
// qsilu_div
// Denominator build and pipelined restoring divide, one quotient bit a stage.
// ----------------------------------------------------------------------------
module qsilu_div
  import qsilu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] in_v,
  input  logic signed [7:0]  in_n,
  input  logic [31:0]        in_e,
  output logic               out_valid,
  output logic signed [31:0] out_t
);

  logic [DIV_LAT-1:0] vld;
  logic [63:0]        den_q  [0:32];
  logic               neg_q  [0:33];
  logic               zero_q [0:33];
  logic [31:0]        mag0;
  logic [63:0]        rem_q  [1:32];
  logic [31:0]        low_q  [1:33];
  logic signed [31:0] t_q;

  logic [63:0] eshift;
  logic [7:0]  rsh;
  logic        zero_c;
  logic [63:0] den_c;
  logic [31:0] vbits;
  logic [31:0] mag_c;
  logic [63:0] num;

  always_comb begin
    rsh    = 8'd0 - in_n;
    eshift = in_n[7] ? ({32'd0, in_e} >> rsh) : ({32'd0, in_e} << in_n[4:0]);
    zero_c = in_n > 8'sd30;
    den_c  = zero_c ? ONE_Q30 : (ONE_Q30 + eshift);
    vbits  = in_v;
    mag_c  = in_v[31] ? (~vbits + 32'd1) : vbits;
  end

  // magnitude * 2^30 plus half the divisor, rounds to nearest
  assign num = {2'd0, mag0, 30'd0} + {1'b0, den_q[0][63:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_q[0]  <= den_c;
      neg_q[0]  <= in_v[31];
      zero_q[0] <= zero_c;
      mag0      <= mag_c;
      den_q[1]  <= den_q[0];
      neg_q[1]  <= neg_q[0];
      zero_q[1] <= zero_q[0];
      rem_q[1]  <= {32'd0, num[63:32]};
      low_q[1]  <= num[31:0];
      t_q <= zero_q[33] ? 32'sd0 : (neg_q[33] ? $signed(~low_q[33] + 32'd1)
                                              : $signed(low_q[33]));
    end
  end

  for (genvar s = 2; s <= 33; s++) begin : g_step
    logic [63:0] cand;
    logic        take;
    assign cand = {rem_q[s-1][62:0], low_q[s-1][31]};
    assign take = cand >= den_q[s-1];
    always_ff @(posedge clk) begin
      if (en) begin
        low_q[s]  <= {low_q[s-1][30:0], take};
        neg_q[s]  <= neg_q[s-1];
        zero_q[s] <= zero_q[s-1];
      end
    end
    if (s <= 32) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[s] <= take ? (cand - den_q[s-1]) : cand;
          den_q[s] <= den_q[s-1];
        end
      end
    end
  end

  assign out_valid = vld[DIV_LAT-1];
  assign out_t     = t_q;

endmodule

// ===== rtl/core/qsilu_requant.sv =====
// ----------------------------------------------------------------------------
// qsilu_requant
// Channel smoothing product, output scaling, rounding and saturation.
// ----------------------------------------------------------------------------
module qsilu_requant
  import qsilu_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [31:0]         in_t,
  input  logic signed [FACTOR_W-1:0] in_factor,
  input  req_cfg_t                   cfg,
  output logic                       out_valid,
  output logic [7:0]                 out_quantized,
  output logic                       out_clipped
);

  logic [3:0]         vld;
  logic signed [55:0] prod0;
  logic signed [31:0] t0;
  logic signed [31:0] t1;
  logic signed [65:0] prod2;
  logic [7:0]         q3;
  logic               c3;

  logic [55:0]        pm0;
  logic [39:0]        rq;
  logic signed [40:0] sv;
  logic signed [31:0] sat_c;
  logic [65:0]        pm2;
  logic               up2;
  logic [25:0]        qmag;
  logic signed [27:0] qs;
  logic signed [27:0] qz;

  always_comb begin
    pm0 = prod0[55] ? (56'd0 - prod0) : prod0;
    rq  = 40'((pm0 + 56'd32768) >> 16);
    sv  = prod0[55] ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
    if (sv > 41'sd2147483647) begin
      sat_c = 32'sh7fff_ffff;
    end else if (sv < -41'sd2147483648) begin
      sat_c = 32'sh8000_0000;
    end else begin
      sat_c = sv[31:0];
    end
  end

  // round half to even at bit 40
  always_comb begin
    pm2  = prod2[65] ? (66'd0 - prod2) : prod2;
    up2  = (pm2[39:0] > {1'b1, 39'd0}) || ((pm2[39:0] == {1'b1, 39'd0}) && pm2[40]);
    qmag = pm2[65:40] + {25'd0, up2};
    qs   = prod2[65] ? -$signed({2'b0, qmag}) : $signed({2'b0, qmag});
    qz   = qs + $signed({20'd0, cfg.output_zero_point});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod0 <= 56'(in_t) * 56'(in_factor);
      t0    <= in_t;
      t1    <= cfg.use_smooth ? sat_c : t0;
      prod2 <= 66'(t1) * 66'($signed({1'b0, cfg.inverse_output_scale}));
      if (qz < 0) begin
        q3 <= 8'd0;
        c3 <= 1'b1;
      end else if (qz > 28'sd255) begin
        q3 <= 8'd255;
        c3 <= 1'b1;
      end else begin
        q3 <= qz[7:0];
        c3 <= 1'b0;
      end
    end
  end

  assign out_valid     = vld[3];
  assign out_quantized = q3;
  assign out_clipped   = c3;

endmodule

// ===== rtl/core/quantized_silu_channel_scale.sv =====
// ----------------------------------------------------------------------------
// quantized_silu_channel_scale
// Quantized SiLU with per-channel smoothing and uint8 requantization.
// ----------------------------------------------------------------------------
// One transaction per clock while the spare output entry is empty. A sample
// passes dequantize, the exp pipeline, the divider (one quotient bit per stage)
// and requantize to the output register. Table writes (cmd 1) use the
// same input channel, give no result and take effect in order with samples.
// The smooth table is a single-port 1024 x 24 RAM with one access per input
// transaction; its entries are undefined until written and are not cleared.
// The whole pipeline stalls only when the output register and its spare
// entry are both full.
module quantized_silu_channel_scale
  import qsilu_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       cmd,
  input  logic [7:0]                 sample,
  input  logic [9:0]                 channel,
  input  logic signed [FACTOR_W-1:0] factor,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 quantized,
  output logic                       clipped,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                cfg_data
);

  localparam int FLINE = EXP_LAT + DIV_LAT + 1;

  logic [31:0] input_scale;
  logic [7:0]  input_zero_point;
  logic [31:0] inverse_output_scale;
  logic [7:0]  output_zero_point;
  logic        use_smooth;
  req_cfg_t    req_cfg;

  logic        en;
  logic        accept;
  logic        in_range;
  logic [FACTOR_W-1:0] rdata;

  logic               vld1;
  logic signed [8:0]  d1;
  logic               inr1;
  logic               vld2;
  logic signed [31:0] v2;
  logic signed [41:0] vprod;
  logic signed [31:0] vsat;
  logic signed [FACTOR_W-1:0] f_line [FLINE];

  logic               exp_valid;
  logic signed [31:0] exp_v;
  logic signed [7:0]  exp_n;
  logic [31:0]        exp_e;
  logic               div_valid;
  logic signed [31:0] div_t;
  logic               pipe_valid;
  logic [7:0]         pipe_q;
  logic               pipe_c;

  logic       spare_valid;
  logic [7:0] spare_q;
  logic       spare_c;
  logic       out_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_scale          <= RST_INPUT_SCALE;
      input_zero_point     <= 8'd0;
      inverse_output_scale <= RST_INV_OUT_SCALE;
      output_zero_point    <= 8'd0;
      use_smooth           <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INPUT_SCALE:   input_scale          <= cfg_data;
        REG_INPUT_ZP:      input_zero_point     <= cfg_data[7:0];
        REG_INV_OUT_SCALE: inverse_output_scale <= cfg_data;
        REG_OUTPUT_ZP:     output_zero_point    <= cfg_data[7:0];
        REG_USE_SMOOTH:    use_smooth           <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign req_cfg = '{inverse_output_scale: inverse_output_scale,
                     output_zero_point:    output_zero_point,
                     use_smooth:           use_smooth};

  assign en       = !spare_valid;
  assign in_ready = en;
  assign accept   = in_valid && in_ready;
  assign in_range = {7'd0, channel} < 17'(CHANNELS);

  // table access sits at the input so writes and reads stay in order
  qsilu_ram #(
    .WIDTH (FACTOR_W),
    .DEPTH (CHANNELS)
  ) u_table (
    .clk   (clk),
    .we    (accept && cmd && in_range),
    .re    (accept && !cmd),
    .addr  (ADDR_W'(channel)),
    .wdata (factor),
    .rdata (rdata)
  );

  always_comb begin
    vprod = 42'(d1) * 42'($signed({1'b0, input_scale}));
    if (vprod > 42'sd2147483647) begin
      vsat = 32'sh7fff_ffff;
    end else if (vprod < -42'sd2147483648) begin
      vsat = 32'sh8000_0000;
    end else begin
      vsat = vprod[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else if (en) begin
      vld1 <= accept && !cmd;
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1        <= $signed({1'b0, sample}) - $signed({1'b0, input_zero_point});
      inr1      <= in_range;
      v2        <= vsat;
      f_line[0] <= inr1 ? $signed(rdata) : '0;
      for (int k = 1; k < FLINE; k++) begin
        f_line[k] <= f_line[k-1];
      end
    end
  end

  qsilu_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vld2),
    .in_v      (v2),
    .out_valid (exp_valid),
    .out_v     (exp_v),
    .out_n     (exp_n),
    .out_e     (exp_e)
  );

  qsilu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (exp_valid),
    .in_v      (exp_v),
    .in_n      (exp_n),
    .in_e      (exp_e),
    .out_valid (div_valid),
    .out_t     (div_t)
  );

  qsilu_requant u_requant (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (div_valid),
    .in_t          (div_t),
    .in_factor     (f_line[FLINE-1]),
    .cfg           (req_cfg),
    .out_valid     (pipe_valid),
    .out_quantized (pipe_q),
    .out_clipped   (pipe_c)
  );

  // output register plus one spare entry
  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (spare_valid) begin
      if (out_take) begin
        spare_valid <= 1'b0;
      end
    end else if (pipe_valid) begin
      if (out_valid && !out_take) begin
        spare_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (spare_valid) begin
      if (out_take) begin
        quantized <= spare_q;
        clipped   <= spare_c;
      end
    end else if (pipe_valid) begin
      if (out_valid && !out_take) begin
        spare_q <= pipe_q;
        spare_c <= pipe_c;
      end else begin
        quantized <= pipe_q;
        clipped   <= pipe_c;
      end
    end
  end

endmodule

// ===== rtl/core/qsilu_checker.sv =====
// ----------------------------------------------------------------------------
// qsilu_checker
// Port-level checks of the quantized SiLU block, bound to the top level.
// ----------------------------------------------------------------------------
`include "quantized_silu_channel_scale_assert.svh"

module qsilu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] quantized,
  input logic       clipped
);

  // a held result keeps its value
  `QSCS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(quantized) && $stable(clipped))

  // saturation flag only with an end-of-range byte
  `QSCS_ASSERT_IMP(a_clip_range, out_valid && (quantized != 8'd0) && (quantized != 8'd255), !clipped)

  // the input side stalls only behind a full output buffer
  `QSCS_ASSERT_IMP(a_stall_full, !in_ready, out_valid)

  // stall starts only after a refused result
  `QSCS_ASSERT_IMP(a_stall_cause, $fell(in_ready), $past(out_valid && !out_ready))

endmodule

bind quantized_silu_channel_scale qsilu_checker u_qsilu_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Streams samples and smooth-table writes through the quantized SiLU block
// under several register settings, with random gaps and output stalls, and
// checks every result byte and clip flag against a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import qsilu_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;
  localparam int IDLE_LIMIT   = 4000;
  localparam int SETTLE       = 80;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic                       cmd;
  logic [7:0]                 sample;
  logic [9:0]                 channel;
  logic signed [FACTOR_W-1:0] factor;
  logic                       out_valid;
  logic                       out_ready;
  logic [7:0]                 quantized;
  logic                       clipped;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [31:0]                cfg_data;

  quantized_silu_channel_scale dut (.*);

  class silu_scoreboard;
    bit [31:0] in_scale = RST_INPUT_SCALE;
    bit [7:0]  in_zp = 0;
    bit [31:0] inv_scale = RST_INV_OUT_SCALE;
    bit [7:0]  out_zp = 0;
    bit        smooth_on = 1;
    logic signed [23:0] factors [CHANNELS];
    bit [8:0]  expected_bytes [$];
    int        errors = 0;

    function void report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        REG_INPUT_SCALE:   in_scale = d;
        REG_INPUT_ZP:      in_zp = d[7:0];
        REG_INV_OUT_SCALE: inv_scale = d;
        REG_OUTPUT_ZP:     out_zp = d[7:0];
        REG_USE_SMOOTH:    smooth_on = d[0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // round half to even after dropping sh bits
    function longint round_even(longint x, int sh);
      longint unsigned m, q, rem, half;
      m = (x < 0) ? -x : x;
      q = m >> sh;
      rem = m & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q++;
      return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    // nearest, ties away from zero
    function longint round_div(longint num, longint unsigned den);
      longint unsigned m, q;
      m = (num < 0) ? -num : num;
      q = (m + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint silu_fixed(longint v);
      longint x, n, r, p, e, sh;
      longint unsigned den;
      x = -v;
      if (x > 64'sd1476395008) x = 64'sd1476395008;
      if (x < -64'sd1476395008) x = -64'sd1476395008;
      n = round_even(x * 64'sd1549082005, 54);
      r = (x * 64'sd65536 - n * (64'sd355 <<< 31) + n * 64'sd233310254) / 64'sd1024;
      p = 64'sd213414;
      p = p * r / 64'sd1073741824 + 64'sd1501306;
      p = p * r / 64'sd1073741824 + 64'sd8947976;
      p = p * r / 64'sd1073741824 + 64'sd44738308;
      p = p * r / 64'sd1073741824 + 64'sd178956958;
      p = p * r / 64'sd1073741824 + 64'sd536870925;
      e = (p * r / 64'sd1073741824) * r / 64'sd1073741824 + r + 64'sd1073741824;
      if (e < 0) e = 0;
      if (n > 30) return 0;
      if (n >= 0) begin
        den = 64'd1073741824 + (longint'(e) << n);
      end else begin
        sh = -n;
        if (sh > 63) sh = 63;
        den = 64'd1073741824 + (longint'(e) >> sh);
      end
      return round_div(v * 64'sd1073741824, den);
    endfunction

    function void note_input(bit c, bit [7:0] s, bit [9:0] ch, logic signed [23:0] f);
      longint v, t, q;
      bit clip;
      if (c == CMD_WRITE) begin
        factors[ch] = f;
        return;
      end
      v = clamp32((longint'(s) - longint'(in_zp)) * longint'(in_scale));
      t = silu_fixed(v);
      if (smooth_on) t = clamp32(round_div(t * longint'(factors[ch]), 65536));
      q = round_even(t * longint'(inv_scale), 40) + longint'(out_zp);
      clip = 0;
      if (q < 0) begin
        q = 0;
        clip = 1;
      end
      if (q > 255) begin
        q = 255;
        clip = 1;
      end
      expected_bytes.push_back({clip, q[7:0]});
    endfunction

    function void check_result(bit [7:0] got_q, bit got_clip);
      bit [8:0] want;
      if (expected_bytes.size() == 0) begin
        report("unexpected result, quantized", got_q, -1);
        return;
      end
      want = expected_bytes.pop_front();
      if (got_q != want[7:0]) report("quantized", got_q, want[7:0]);
      if (got_clip != want[8]) report("clipped", got_clip, want[8]);
    endfunction
  endclass

  silu_scoreboard sb = new();
  bit [9:0] written_ch [$];
  bit tx_gaps, rx_stalls;
  int hold_req, hold_done;
  int hold_left, stall_left, idle_cycles;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int r;
    out_ready = 0;
    hold_left = 0;
    stall_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else if (hold_done != hold_req) begin
        hold_done = hold_req;
        hold_left = 400;
        out_ready <= 0;
      end else if (!rx_stalls) begin
        out_ready <= 1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          out_ready <= 1;
        end else begin
          out_ready <= 0;
          stall_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(20, 60);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(quantized, clipped);
  end

  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic send_item(bit c, bit [7:0] s, bit [9:0] ch, bit [23:0] f);
    int gap, r;
    gap = 0;
    if (tx_gaps) begin
      r = $urandom_range(0, 99);
      if (r >= 60) gap = (r < 95) ? $urandom_range(1, 3) : $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    cmd <= c;
    sample <= s;
    channel <= ch;
    factor <= f;
    do @(negedge clk); while (!in_ready);
    sb.note_input(c, s, ch, f);
    if (c == CMD_WRITE) written_ch.push_back(ch);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(negedge clk); while (!cfg_ready);
    sb.apply_reg(idx, d);
    @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.expected_bytes.size() > 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(bit [31:0] scl, bit [7:0] izp, bit [31:0] inv, bit [7:0] ozp,
                           bit sm, int count, bit gaps, bit stalls, bit pressure);
    bit [9:0] ch;
    write_reg(REG_INPUT_SCALE, scl);
    write_reg(REG_INPUT_ZP, izp);
    write_reg(REG_INV_OUT_SCALE, inv);
    write_reg(REG_OUTPUT_ZP, ozp);
    write_reg(REG_USE_SMOOTH, sm);
    tx_gaps = gaps;
    rx_stalls = stalls;
    if (pressure) hold_req++;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 12) begin
        send_item(CMD_WRITE, 8'($urandom), 10'($urandom_range(0, 1023)), 24'($urandom));
      end else begin
        // smoothing on: only channels that hold a factor
        ch = sm ? written_ch[$urandom_range(0, written_ch.size() - 1)]
                : 10'($urandom_range(0, 1023));
        send_item(CMD_SAMPLE, 8'($urandom), ch, 24'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    cmd = 0;
    sample = 0;
    channel = 0;
    factor = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    tx_gaps = 1;
    rx_stalls = 1;
    hold_req = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // unknown register index is ignored
    write_reg(REG_UNUSED, 32'hffff_ffff);

    // directed: factor extremes, channel ends, sample extremes, reset settings
    send_item(CMD_WRITE, 8'hff, 10'd0, 24'h7fffff);
    send_item(CMD_WRITE, 8'h00, 10'd1023, 24'h800000);
    send_item(CMD_WRITE, 8'h5a, 10'd5, 24'h010000);
    send_item(CMD_WRITE, 8'h00, 10'd7, 24'h000000);
    send_item(CMD_WRITE, 8'h00, 10'd9, 24'hff0000);
    foreach (written_ch[k]) begin
      send_item(CMD_SAMPLE, 8'd0, written_ch[k], 24'h000000);
      send_item(CMD_SAMPLE, 8'd255, written_ch[k], 24'hffffff);
      send_item(CMD_SAMPLE, 8'd3, written_ch[k], 24'h000000);
    end
    drain();

    run_phase(32'h0020_0000, 8'd128, 32'h0004_0000, 8'd128, 1'b1, 200, 1, 1, 0);
    run_phase(32'h0000_0000, 8'd0, 32'hffff_ffff, 8'd255, 1'b0, 60, 1, 1, 0);
    run_phase(32'hffff_ffff, 8'd255, 32'h0000_0000, 8'd0, 1'b1, 60, 1, 1, 0);
    run_phase(32'hffff_ffff, 8'd0, 32'hffff_ffff, 8'd0, 1'b0, 40, 1, 1, 0);
    for (int ph = 0; ph < 6; ph++) begin
      run_phase($urandom_range(1 << 18, 1 << 22), 8'($urandom),
                $urandom_range(1 << 16, 1 << 22), 8'($urandom),
                ph[0], 220, ph != 2 && ph != 4, ph != 4, ph == 2);
    end

    if (sb.errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/qsilu_pkg.sv
rtl/core/qsilu_ram.sv
rtl/core/qsilu_exp.sv
rtl/core/qsilu_div.sv
rtl/core/qsilu_requant.sv
rtl/core/quantized_silu_channel_scale.sv
rtl/core/qsilu_checker.sv
tb/tb_top.sv
